FILE: rtl/jsu_pkg.sv
// shared types, codes and constants for the json string unescape block
`default_nettype none
package jsu_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CAP_BITS   = 16;
	localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_STRING = 2'd1;
	localparam logic [1:0] ST_OVERFLOW   = 2'd2;
	localparam logic [1:0] ST_BAD_CHAR   = 2'd3;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DEL       = 8'h7f;

	typedef struct packed {
		logic [1:0]            phase;
		logic [COUNT_BITS-1:0] count;
		logic                  dropped;
	} jsu_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       is_end;
		logic [1:0] status;
	} jsu_result_t;

endpackage
`default_nettype wire

FILE: rtl/json_string_unescape.sv
// top level of the json string unescape block
// Decodes one JSON string literal per run from a byte stream, one byte per clock cycle
// sustained while the master side does not stall it. A byte is registered on acceptance
// and decoded into the output register once that register can advance; each byte
// gives at most one transaction on the master side: a content byte (tlast low, tuser ok) or an
// end marker with tdata zero, tlast high and the status in tuser. Whitespace before the
// opening quote is skipped; unknown escapes are consumed silently. The capacity register
// at address 0 limits content to capacity minus one bytes; extra bytes are dropped and
// reported as overflow on the closing quote. Write capacity only while the block is idle.
`default_nettype none
module json_string_unescape (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,   // [7:0] out_byte
	output logic             m_tlast,   // is_end
	output logic      [1:0]  m_tuser,   // [1:0] status
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [jsu_pkg::CAP_BITS-1:0] capacity;
	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         out_valid_q;
	logic [7:0]                   out_data_q;
	logic                         out_last_q;
	logic [1:0]                   out_status_q;
	logic                         advance;
	jsu_pkg::jsu_state_t          state_q;
	jsu_pkg::jsu_state_t          state_nxt;
	jsu_pkg::jsu_result_t         res;

	jsu_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	jsu_decode u_decode (
		.in_byte  (byte_s1),
		.cur      (state_q),
		.capacity (capacity),
		.nxt      (state_nxt),
		.res      (res)
	);

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= jsu_pkg::PH_WAIT;
			state_q.count   <= '0;
			state_q.dropped <= 1'b0;
			out_valid_q     <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.valid;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.valid) begin
			out_data_q   <= res.data;
			out_last_q   <= res.is_end;
			out_status_q <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

endmodule
`default_nettype wire

FILE: rtl/jsu_apb_regs.sv
// apb configuration register holding the destination capacity
`default_nettype none
module jsu_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output logic      [jsu_pkg::CAP_BITS-1:0] capacity
);

	logic [jsu_pkg::CAP_BITS-1:0] capacity_q;

	assign pready   = 1'b1;
	assign capacity = capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= jsu_pkg::CAP_BITS'(256);
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			capacity_q <= pwdata[jsu_pkg::CAP_BITS-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (!paddr[2]) begin
			prdata = {{(32 - jsu_pkg::CAP_BITS){1'b0}}, capacity_q};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/jsu_decode.sv
// per-byte decode: next literal state and the result caused by one byte
`default_nettype none
module jsu_decode (
	input  wire logic [7:0]                   in_byte,
	input  wire jsu_pkg::jsu_state_t          cur,
	input  wire logic [jsu_pkg::CAP_BITS-1:0] capacity,
	output jsu_pkg::jsu_state_t               nxt,
	output jsu_pkg::jsu_result_t              res
);

	logic [jsu_pkg::CMP_BITS-1:0]   count_w;
	logic [jsu_pkg::CMP_BITS-1:0]   limit_w;
	logic [jsu_pkg::COUNT_BITS-1:0] count_max;
	logic                           room;
	logic                           is_content;
	logic [7:0]                     content_byte;
	logic                           esc_known;
	logic [7:0]                     esc_byte;

	assign count_w   = jsu_pkg::CMP_BITS'(cur.count);
	assign limit_w   = jsu_pkg::CMP_BITS'(capacity - jsu_pkg::CAP_BITS'(1));
	assign count_max = '1;
	// below min(capacity-1, counter max)
	assign room      = (count_w < limit_w) && (cur.count != count_max);

	always_comb begin
		esc_known = 1'b1;
		esc_byte  = 8'h00;
		case (in_byte)
			8'h22:   esc_byte = 8'h22;
			8'h5c:   esc_byte = 8'h5c;
			8'h2f:   esc_byte = 8'h2f;
			8'h62:   esc_byte = 8'h08;
			8'h66:   esc_byte = 8'h0c;
			8'h6e:   esc_byte = 8'h0a;
			8'h72:   esc_byte = 8'h0d;
			8'h74:   esc_byte = 8'h09;
			default: esc_known = 1'b0;
		endcase
	end

	always_comb begin
		nxt          = cur;
		res          = '0;
		is_content   = 1'b0;
		content_byte = in_byte;
		case (cur.phase)
			jsu_pkg::PH_BODY: begin
				if (in_byte == jsu_pkg::CH_BACKSLASH) begin
					nxt.phase = jsu_pkg::PH_ESC;
				end else if (in_byte == jsu_pkg::CH_QUOTE) begin
					nxt.phase  = jsu_pkg::PH_WAIT;
					res.valid  = 1'b1;
					res.is_end = 1'b1;
					res.status = cur.dropped ? jsu_pkg::ST_OVERFLOW : jsu_pkg::ST_OK;
				end else if (in_byte < jsu_pkg::CH_SPACE || in_byte >= jsu_pkg::CH_DEL) begin
					nxt.phase  = jsu_pkg::PH_WAIT;
					res.valid  = 1'b1;
					res.is_end = 1'b1;
					res.status = jsu_pkg::ST_BAD_CHAR;
				end else begin
					is_content = 1'b1;
				end
			end
			jsu_pkg::PH_ESC: begin
				nxt.phase    = jsu_pkg::PH_BODY;
				is_content   = esc_known;
				content_byte = esc_byte;
			end
			default: begin
				nxt.phase = jsu_pkg::PH_WAIT;
				if (in_byte inside {8'h20, 8'h09, 8'h0d, 8'h0a}) begin
					nxt.phase = jsu_pkg::PH_WAIT;
				end else if (in_byte == jsu_pkg::CH_QUOTE) begin
					nxt.phase   = jsu_pkg::PH_BODY;
					nxt.count   = '0;
					nxt.dropped = 1'b0;
				end else begin
					res.valid  = 1'b1;
					res.is_end = 1'b1;
					res.status = jsu_pkg::ST_NOT_STRING;
				end
			end
		endcase

		// zero capacity keeps all content silent, no drop flag
		if (is_content && capacity != '0) begin
			if (room) begin
				nxt.count = cur.count + jsu_pkg::COUNT_BITS'(1);
				res.valid = 1'b1;
				res.data  = content_byte;
			end else begin
				nxt.dropped = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
